/* design/uartrb_pkg.sv */
// Shared types and constants for the UART receive/transmit ring buffer block.
// No dependencies; every other design file imports this package.
package uartrb_pkg;

  localparam int UARTRB_RING_DEPTH = 128;
  localparam int OPCODE_W          = 2;
  localparam int BYTE_W            = 8;
  localparam int STATUS_W          = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LINE_RX   = 2'd0,
    OP_TX_READY  = 2'd1,
    OP_CPU_WRITE = 2'd2,
    OP_CPU_READ  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED         = 3'd0,
    ST_DROPPED_FULL   = 3'd1,
    ST_SENT           = 3'd2,
    ST_TX_IDLE        = 3'd3,
    ST_WRITE_REJECTED = 3'd4,
    ST_READ_OK        = 3'd5,
    ST_READ_EMPTY     = 3'd6
  } status_t;

endpackage

/* design/uartrb_if.sv */
// Valid/ready channel interfaces for the request and result sides of the block.
// Depends on uartrb_pkg for field widths.
interface uartrb_in_if import uartrb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0]   data_in;

  modport source (output valid, output opcode, output data_in, input ready);
  modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface uartrb_out_if import uartrb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   data_out;
  logic                rx_irq_enable;
  logic                tx_irq_enable;

  modport source (output valid, output status, output data_out, output rx_irq_enable,
                  output tx_irq_enable, input ready);
  modport sink   (input valid, input status, input data_out, input rx_irq_enable,
                  input tx_irq_enable, output ready);
endinterface

/* design/uart_rx_tx_ring_buffers_core.sv */
// An accepted request is registered in the middle stage, then in the output register.
// Throughput: one request per cycle unless the result side stalls; the ring pointers
// live in flops and each ring memory has one write and one registered read port.
// A stalled result stalls the request side only once the single middle stage is also full.
// Reset (synchronous, rst_n low) clears the pointers, the interrupt enables and all
// valid flags; the ring memories are not cleared.
module uart_rx_tx_ring_buffers_core import uartrb_pkg::*; #(
  parameter int RING_DEPTH = UARTRB_RING_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  uartrb_in_if.sink    in_ch,
  uartrb_out_if.source out_ch
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_RX,
    SRC_TX
  } src_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic [BYTE_W-1:0] rx_mem [RING_DEPTH];
  logic [BYTE_W-1:0] tx_mem [RING_DEPTH];
  logic [BYTE_W-1:0] rx_rd_r, tx_rd_r;

  logic [PTR_W-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [PTR_W-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic             rx_en_r, rx_en_nxt, tx_en_r, tx_en_nxt;

  logic    p_valid_r, p_rx_en_r, p_tx_en_r;
  status_t p_status_r, status_nxt;
  src_t    p_src_r, src_nxt;

  logic              out_valid_r, out_rx_en_r, out_tx_en_r;
  status_t           out_status_r;
  logic [BYTE_W-1:0] out_data_r;

  logic accept, p_move;
  logic rx_wr, rx_rd, tx_wr, tx_rd;

  assign p_move      = p_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !p_valid_r || p_move;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    rx_en_nxt   = rx_en_r;
    tx_en_nxt   = tx_en_r;
    status_nxt  = ST_STORED;
    src_nxt     = SRC_NONE;
    rx_wr       = 1'b0;
    rx_rd       = 1'b0;
    tx_wr       = 1'b0;
    tx_rd       = 1'b0;
    if (accept) begin
      case (opcode_t'(in_ch.opcode))
        OP_LINE_RX: begin
          if (ptr_next(rx_tail_r) == rx_head_r) begin
            status_nxt = ST_DROPPED_FULL;
            rx_en_nxt  = 1'b0;
          end else begin
            rx_wr       = 1'b1;
            rx_tail_nxt = ptr_next(rx_tail_r);
            status_nxt  = ST_STORED;
            rx_en_nxt   = 1'b1;
          end
        end
        OP_TX_READY: begin
          if (tx_head_r == tx_tail_r) begin
            status_nxt = ST_TX_IDLE;
            tx_en_nxt  = 1'b0;
          end else begin
            tx_rd       = 1'b1;
            tx_head_nxt = ptr_next(tx_head_r);
            status_nxt  = ST_SENT;
            src_nxt     = SRC_TX;
            tx_en_nxt   = 1'b1;
          end
        end
        OP_CPU_WRITE: begin
          tx_en_nxt = 1'b1;
          if (ptr_next(tx_tail_r) == tx_head_r) begin
            status_nxt = ST_WRITE_REJECTED;
          end else begin
            tx_wr       = 1'b1;
            tx_tail_nxt = ptr_next(tx_tail_r);
            status_nxt  = ST_STORED;
          end
        end
        OP_CPU_READ: begin
          rx_en_nxt = 1'b1;
          if (rx_head_r == rx_tail_r) begin
            status_nxt = ST_READ_EMPTY;
          end else begin
            rx_rd       = 1'b1;
            rx_head_nxt = ptr_next(rx_head_r);
            status_nxt  = ST_READ_OK;
            src_nxt     = SRC_RX;
          end
        end
        default: begin
          status_nxt = ST_STORED;
        end
      endcase
    end
  end

  // A pop only reaches entries written at an earlier edge, so the registered read
  // never races a write to the same entry. The read registers hold while the middle
  // stage is stalled, because no request is accepted then.
  always_ff @(posedge clk) begin
    if (rx_wr) begin
      rx_mem[rx_tail_r] <= in_ch.data_in;
    end
    if (rx_rd) begin
      rx_rd_r <= rx_mem[rx_head_r];
    end
    if (tx_wr) begin
      tx_mem[tx_tail_r] <= in_ch.data_in;
    end
    if (tx_rd) begin
      tx_rd_r <= tx_mem[tx_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      rx_en_r     <= 1'b0;
      tx_en_r     <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rx_head_r <= rx_head_nxt;
      rx_tail_r <= rx_tail_nxt;
      tx_head_r <= tx_head_nxt;
      tx_tail_r <= tx_tail_nxt;
      rx_en_r   <= rx_en_nxt;
      tx_en_r   <= tx_en_nxt;
      if (accept) begin
        p_valid_r <= 1'b1;
      end else if (p_move) begin
        p_valid_r <= 1'b0;
      end
      if (p_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_status_r <= status_nxt;
      p_src_r    <= src_nxt;
      p_rx_en_r  <= rx_en_nxt;
      p_tx_en_r  <= tx_en_nxt;
    end
    if (p_move) begin
      out_status_r <= p_status_r;
      out_rx_en_r  <= p_rx_en_r;
      out_tx_en_r  <= p_tx_en_r;
      case (p_src_r)
        SRC_RX:  out_data_r <= rx_rd_r;
        SRC_TX:  out_data_r <= tx_rd_r;
        default: out_data_r <= '0;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.data_out      = out_data_r;
  assign out_ch.rx_irq_enable = out_rx_en_r;
  assign out_ch.tx_irq_enable = out_tx_en_r;

endmodule

/* design/uartrb_checker.sv */
// Port-level checks for the UART ring buffer core, attached by the bind below.
// Depends on uartrb_pkg for the status codes.
module uartrb_checker import uartrb_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [BYTE_W-1:0]   out_data,
  input logic                out_rx_irq,
  input logic                out_tx_irq
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Every accepted request is followed by a result showing at the output, its own or an older one.
  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted request produced no result");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_SENT && out_status != ST_READ_OK |-> out_data == '0)
    else $error("nonzero data on a status without a byte");

  a_irq_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      !((out_status == ST_DROPPED_FULL) && out_rx_irq) &&
      !((out_status == ST_TX_IDLE) && out_tx_irq) &&
      !((out_status == ST_SENT || out_status == ST_WRITE_REJECTED) && !out_tx_irq) &&
      !((out_status == ST_READ_OK || out_status == ST_READ_EMPTY) && !out_rx_irq))
    else $error("interrupt enable disagrees with status");

endmodule

bind uart_rx_tx_ring_buffers_core uartrb_checker u_uartrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_data   (out_ch.data_out),
  .out_rx_irq (out_ch.rx_irq_enable),
  .out_tx_irq (out_ch.tx_irq_enable)
);
